### rtl/apg_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the arctangent table for the arc point generator.
// Has no dependencies; the top level imports it.
package apg_pkg;

    // Angles are in 1/64 degree.
    localparam int unsigned FULL_TURN_I    = 23040;
    localparam int unsigned QUARTER_TURN_I = 5760;
    localparam int unsigned EIGHTH_TURN_I  = 2880;

    localparam logic [15:0] FULL_TURN    = 16'(FULL_TURN_I);
    localparam logic [15:0] QUARTER_TURN = 16'(QUARTER_TURN_I);
    localparam logic [15:0] EIGHTH_TURN  = 16'(EIGHTH_TURN_I);

    // Rotation iterations of the CORDIC unit (8 to 24).
    localparam int unsigned ROT_ITERS = 16;
    localparam int unsigned ITER_W    = 5;

    // Points from the stepping loop before the closing point.
    localparam logic [5:0] STEP_POINT_LIMIT = 6'd61;

    // Reset value of the angle step register.
    localparam logic [12:0] STEP_RESET = 13'd960;

    // Inverse CORDIC gain in Q30.
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

    // Working angle: a signed 18-bit count of 1/64 degree.
    typedef logic signed [17:0] t_angle;

    // Arctangent of 2^-i in degrees scaled by 2^22.
    function automatic logic signed [31:0] atan_lookup(input logic [ITER_W-1:0] idx);
        logic signed [31:0] v;
        unique case (idx)
            5'd0:    v = 32'sd188743680;
            5'd1:    v = 32'sd111421900;
            5'd2:    v = 32'sd58872272;
            5'd3:    v = 32'sd29884485;
            5'd4:    v = 32'sd15000234;
            5'd5:    v = 32'sd7507429;
            5'd6:    v = 32'sd3754631;
            5'd7:    v = 32'sd1877430;
            5'd8:    v = 32'sd938729;
            5'd9:    v = 32'sd469366;
            5'd10:   v = 32'sd234683;
            5'd11:   v = 32'sd117342;
            5'd12:   v = 32'sd58671;
            5'd13:   v = 32'sd29335;
            5'd14:   v = 32'sd14668;
            5'd15:   v = 32'sd7334;
            5'd16:   v = 32'sd3667;
            5'd17:   v = 32'sd1833;
            5'd18:   v = 32'sd917;
            5'd19:   v = 32'sd458;
            5'd20:   v = 32'sd229;
            5'd21:   v = 32'sd115;
            5'd22:   v = 32'sd57;
            5'd23:   v = 32'sd29;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/arc_point_generator.sv
`timescale 1ns / 1ps
// Arc point generator top level: sequencer, shared CORDIC rotation unit,
// shared multiplier and saturating placement. Depends on apg_pkg.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | center_x, center_y, radius, angles
//  out     | output    | o_out_valid / i_out_stall | point_x, point_y, last_point
//  config  | input     | APB psel/penable/pwrite   | angle_step at byte address 0
//
// Each point passes through one loop check, one to three turn reductions and
// one to four quadrant reductions through one subtractor, one fold, ROT_ITERS
// rotations of the shared CORDIC stage, and the shared multiplier and
// placement adder for x and then for y. A point waits while the output is
// stalled; an item holds at most 62 points.
// The input is stalled from acceptance until the closing point is loaded.
// Reset is synchronous and active low; it restores the step register to 960.
module arc_point_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_center_x,
    input  logic [31:0] i_center_y,
    input  logic [31:0] i_radius,
    input  logic [14:0] i_start_angle,
    input  logic [14:0] i_finish_angle,
    // Result item channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_point_x,
    output logic [31:0] o_point_y,
    output logic        o_last_point,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import apg_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;
    localparam logic [3:0] S_TURN    = 4'd2;
    localparam logic [3:0] S_QUAD    = 4'd3;
    localparam logic [3:0] S_FOLD    = 4'd4;
    localparam logic [3:0] S_ROT     = 4'd5;
    localparam logic [3:0] S_MUL_X   = 4'd6;
    localparam logic [3:0] S_PLACE_X = 4'd7;
    localparam logic [3:0] S_MUL_Y   = 4'd8;
    localparam logic [3:0] S_PLACE_Y = 4'd9;

    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(ROT_ITERS - 1);

    // Control registers
    logic [3:0]        r_state, n_state;
    logic [12:0]       r_step;
    logic [5:0]        r_count;
    logic [ITER_W-1:0] r_iter;
    logic              r_out_valid;

    // Payload registers
    logic [31:0]        r_cx, r_cy, r_mag;
    logic               r_cw;
    t_angle             r_theta, r_finish;
    logic [15:0]        r_ang;
    logic [1:0]         r_quad;
    logic               r_last;
    logic signed [33:0] r_x, r_y;
    logic signed [31:0] r_z;
    logic signed [63:0] r_prod;
    logic [31:0]        r_px;
    logic [31:0]        r_point_x, r_point_y;
    logic               r_last_point;

    // Handshakes
    logic w_in_acc, w_out_free, w_cfg_wr;
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_cfg_wr   = psel && penable && pwrite && (paddr[2] == 1'b0);

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_point_x    = r_point_x;
    assign o_point_y    = r_point_y;
    assign o_last_point = r_last_point;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == 1'b0) ? {19'd0, r_step} : 32'd0;

    // Request setup: wrap the finish angle and pick the starting theta.
    logic   w_wrap;
    t_angle w_start, w_finish_adj;
    assign w_wrap       = (i_start_angle > i_finish_angle);
    assign w_start      = t_angle'({3'd0, i_start_angle})
                          + (i_radius[31] ? t_angle'({2'd0, FULL_TURN}) : t_angle'(0));
    assign w_finish_adj = t_angle'({3'd0, i_finish_angle})
                          + (w_wrap ? t_angle'({2'd0, FULL_TURN}) : t_angle'(0));

    // Loop test: another stepped point, or the closing point.
    logic w_more;
    assign w_more = (r_cw ? (r_theta > r_finish) : (r_theta < r_finish))
                    && (r_count != STEP_POINT_LIMIT);

    // Shared subtractor for the turn and quadrant reductions.
    logic [15:0] w_sub_k;
    logic [16:0] w_diff;
    logic        w_ge;
    assign w_sub_k = (r_state == S_TURN) ? FULL_TURN : QUARTER_TURN;
    assign w_diff  = {1'b0, r_ang} - {1'b0, w_sub_k};
    assign w_ge    = !w_diff[16];

    // Fold the quadrant residual into -45..45 degrees.
    logic               w_fold;
    logic signed [13:0] w_res;
    assign w_fold = (r_ang > EIGHTH_TURN);
    assign w_res  = w_fold ? ({1'b0, r_ang[12:0]} - {1'b0, QUARTER_TURN[12:0]})
                           : {1'b0, r_ang[12:0]};

    // One CORDIC rotation stage.
    logic signed [33:0] w_dx, w_dy;
    logic signed [31:0] w_atan;
    assign w_dx   = r_y >>> r_iter;
    assign w_dy   = r_x >>> r_iter;
    assign w_atan = atan_lookup(r_iter);

    // Quadrant mapping to cosine and sine.
    logic signed [33:0] w_cos, w_sin;
    always_comb begin
        unique case (r_quad)
            2'd0: begin
                w_cos = r_x;
                w_sin = r_y;
            end
            2'd1: begin
                w_cos = -r_y;
                w_sin = r_x;
            end
            2'd2: begin
                w_cos = -r_x;
                w_sin = -r_y;
            end
            default: begin
                w_cos = r_y;
                w_sin = -r_x;
            end
        endcase
    end

    // Shared multiplier: radius magnitude times cosine or sine in Q30.
    logic signed [31:0] w_trig;
    logic signed [64:0] w_prod;
    assign w_trig = (r_state == S_MUL_X) ? w_cos[31:0] : w_sin[31:0];
    assign w_prod = $signed({1'b0, r_mag}) * w_trig;

    // Shared placement: round to Q16.16, add the center, saturate.
    logic [31:0]        w_center;
    logic signed [63:0] w_round;
    logic signed [63:0] w_shift;
    logic signed [34:0] w_sum;
    logic [31:0]        w_place;
    assign w_center = (r_state == S_PLACE_X) ? r_cx : r_cy;
    assign w_round  = r_prod + 64'sd536870912;
    assign w_shift  = w_round >>> 30;
    assign w_sum    = $signed({w_shift[33], w_shift[33:0]})
                      + $signed({{3{w_center[31]}}, w_center});
    always_comb begin
        priority if (w_sum > 35'sh0_7FFF_FFFF) begin
            w_place = 32'h7FFF_FFFF;
        end else if (w_sum < -35'sh0_8000_0000) begin
            w_place = 32'h8000_0000;
        end else begin
            w_place = w_sum[31:0];
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (w_in_acc) n_state = S_CHECK;
            S_CHECK:   n_state = S_TURN;
            S_TURN:    if (!w_ge) n_state = S_QUAD;
            S_QUAD:    if (!w_ge) n_state = S_FOLD;
            S_FOLD:    n_state = S_ROT;
            S_ROT:     if (r_iter == LAST_ITER) n_state = S_MUL_X;
            S_MUL_X:   n_state = S_PLACE_X;
            S_PLACE_X: n_state = S_MUL_Y;
            S_MUL_Y:   n_state = S_PLACE_Y;
            S_PLACE_Y: if (w_out_free) n_state = r_last ? S_IDLE : S_CHECK;
            default:   n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= STEP_RESET;
            r_count     <= '0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_step <= pwdata[12:0];
            end
            if (w_in_acc) begin
                r_count <= '0;
            end else if (r_state == S_PLACE_Y && w_out_free && !r_last) begin
                r_count <= r_count + 6'd1;
            end
            if (r_state == S_FOLD) begin
                r_iter <= '0;
            end else if (r_state == S_ROT) begin
                r_iter <= r_iter + ITER_W'(1);
            end
            if (r_state == S_PLACE_Y && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_cx     <= i_center_x;
                    r_cy     <= i_center_y;
                    r_mag    <= i_radius[31] ? (32'd0 - i_radius) : i_radius;
                    r_cw     <= i_radius[31];
                    r_theta  <= w_start;
                    r_finish <= w_finish_adj;
                end
            end
            S_CHECK: begin
                r_ang  <= w_more ? r_theta[15:0] : r_finish[15:0];
                r_last <= !w_more;
            end
            S_TURN: begin
                r_quad <= 2'd0;
                if (w_ge) r_ang <= w_diff[15:0];
            end
            S_QUAD: begin
                if (w_ge) begin
                    r_ang  <= w_diff[15:0];
                    r_quad <= r_quad + 2'd1;
                end
            end
            S_FOLD: begin
                if (w_fold) r_quad <= r_quad + 2'd1;
                r_z <= {{2{w_res[13]}}, w_res, 16'd0};
                r_x <= CORDIC_START;
                r_y <= '0;
            end
            S_ROT: begin
                if (!r_z[31]) begin
                    r_x <= r_x - w_dx;
                    r_y <= r_y + w_dy;
                    r_z <= r_z - w_atan;
                end else begin
                    r_x <= r_x + w_dx;
                    r_y <= r_y - w_dy;
                    r_z <= r_z + w_atan;
                end
            end
            S_MUL_X, S_MUL_Y: begin
                r_prod <= w_prod[63:0];
            end
            S_PLACE_X: begin
                r_px <= w_place;
            end
            S_PLACE_Y: begin
                if (w_out_free) begin
                    r_point_x    <= r_px;
                    r_point_y    <= w_place;
                    r_last_point <= r_last;
                    if (r_cw) begin
                        r_theta <= r_theta - t_angle'({5'd0, r_step});
                    end else begin
                        r_theta <= r_theta + t_angle'({5'd0, r_step});
                    end
                end
            end
            default: begin
                r_ang <= r_ang;
            end
        endcase
    end

endmodule

### rtl/apg_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the arc point generator, bound to the top level.
// Depends only on the top level's ports.
module apg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_point_x,
    input logic [31:0] o_point_y,
    input logic        o_last_point,
    input logic        pready
);

    // A stalled result item stays valid and unchanged.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_point_x)
            && $stable(o_point_y) && $stable(o_last_point))
        else $error("stalled output item changed");

    // An accepted item blocks the input on the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accepting an item");

    // The input opens again only once the closing point is presented.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid && o_last_point)
        else $error("input reopened without a closing point");

    // The configuration port never inserts wait states.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind arc_point_generator apg_checker u_apg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_point_x    (o_point_x),
    .o_point_y    (o_point_y),
    .o_last_point (o_last_point),
    .pready       (pready)
);
